// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps

package tcs_pkg;

   // Control states
   typedef enum logic [1:0] {
      MODE_DISABLE = 2'd0,
      MODE_ENABLE  = 2'd1,
      MODE_WAIT    = 2'd2
   } mode_type;

   // Field widths
   localparam int THROTTLE_W = 12;
   localparam int TORQUE_W   = 16;
   localparam int MAXTQ_W    = 13;
   localparam int FRAME_ID_W = 8;
   localparam int PAYLOAD_W  = 64;
   localparam int MODE_W     = 2;

   // Throttle shaping: deadband and valid window
   localparam logic [THROTTLE_W-1:0] THR_DEADBAND_LO = 12'd1000;
   localparam logic [THROTTLE_W-1:0] THR_DEADBAND_HI = 12'd1300;
   localparam logic [THROTTLE_W-1:0] THR_MIN         = 12'd20;
   localparam logic [THROTTLE_W-1:0] THR_MAX         = 12'd1400;

   // Clamped throttle fits 11 bits, product with full-scale torque fits 24 bits
   localparam int EFF_THR_W = 11;
   localparam int PRODUCT_W = EFF_THR_W + MAXTQ_W;

   // Divide by 100 as a shift by 2 and a reciprocal multiply for 25
   localparam int QUARTER_W  = PRODUCT_W - 2;
   localparam int RECIP_W    = 23;
   localparam int RECIP_SH   = 27;
   localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;
   localparam int PROD2_W    = QUARTER_W + RECIP_W;
   localparam int QUOT_W     = PROD2_W - RECIP_SH;

   // Frame identifiers and fixed payloads
   localparam logic [FRAME_ID_W-1:0] ID_COMMAND     = 8'hC0;
   localparam logic [FRAME_ID_W-1:0] ID_PARAM_WRITE = 8'hC1;
   localparam logic [PAYLOAD_W-1:0]  PAYLOAD_FREE_ROLL   = 64'h0000_0001_0000_0000;
   localparam logic [PAYLOAD_W-1:0]  PAYLOAD_FAULT_CLEAR = 64'h0000_0000_0001_0014;
   localparam logic [PAYLOAD_W-1:0]  PAYLOAD_TORQUE_FLAGS = 64'h0000_0101_0000_0000;

   // Register map
   localparam logic [12:0] FULL_SCALE_RESET = 13'd100;

   // Tick held in the input register
   typedef struct packed {
      logic [PRODUCT_W-1:0] product;
      logic                 in_range;
      logic                 op_error;
      logic                 fault_active;
      logic                 fault_clearable;
      logic                 ack_ok;
   } tick_type;

   // Decision of one tick
   typedef struct packed {
      logic                  emit;
      logic [FRAME_ID_W-1:0] frame_id;
      logic [PAYLOAD_W-1:0]  payload;
      mode_type              mode_next;
      logic [TORQUE_W-1:0]   torque_next;
   } decision_type;

endpackage

// ===== rtl/torque_command_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel    | Dir | Fields (low bit up)
// req_       | in  | throttle[11:0], op_error, fault_active, fault_clearable, ack_ok
// rsp_       | out | frame_id[7:0], payload[63:0], control_mode[1:0], last_torque[15:0]
// csr_       | cfg | full-scale torque at byte address 0
//
// One tick per cycle unless stalled; a tick passes the input and result registers.
// The throttle product is registered with the tick; the divide by 100, the
// state machine and the frame choice run between that register and rsp_.
// A tick that sends no frame only updates the state.
// Reset gives disable state, torque memory 0 and full-scale torque 100.
// rsp_tready low holds the result; the input register then fills and req_tready drops.

module torque_command_sequencer_core import tcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // throttle[11:0], op_error[12], fault_active[13], fault_clearable[14],
   // ack_ok[15]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,
   // frame_id[7:0], payload[71:8], control_mode[73:72], last_torque[89:74],
   // zero fill[95:90]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [MAXTQ_W-1:0]    full_scale_ff;
   logic [THROTTLE_W-1:0] throttle;
   logic [THROTTLE_W-1:0] eff_throttle;
   tick_type              tick_in;
   tick_type              tick_ff;
   logic                  tick_valid_ff;
   logic                  tick_valid_in;
   logic                  req_accept;
   logic                  tick_fire;
   logic                  out_free;
   mode_type              mode_ff;
   mode_type              mode_in;
   logic [TORQUE_W-1:0]   torque_ff;
   logic [TORQUE_W-1:0]   torque_in;
   decision_type          decision;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [FRAME_ID_W-1:0] frame_id_ff;
   logic [PAYLOAD_W-1:0]  payload_ff;
   logic [MODE_W-1:0]     mode_out_ff;
   logic [TORQUE_W-1:0]   torque_out_ff;
   logic                  csr_write;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(full_scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_write && !csr_paddr[2]) begin
         full_scale_ff <= csr_pwdata[MAXTQ_W-1:0];
      end
   end

   // Handshake between the stages
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign tick_fire  = tick_valid_ff && out_free;
   assign req_tready = !tick_valid_ff || tick_fire;
   assign req_accept = req_tvalid && req_tready;

   // Shape throttle and form the product with full-scale torque
   assign throttle     = req_tdata[THROTTLE_W-1:0];
   assign eff_throttle = (throttle > THR_DEADBAND_LO && throttle < THR_DEADBAND_HI)
                       ? THR_DEADBAND_LO : throttle;

   always_comb begin
      tick_in.product         = PRODUCT_W'(eff_throttle[EFF_THR_W-1:0])
                              * PRODUCT_W'(full_scale_ff);
      tick_in.in_range        = !(eff_throttle < THR_MIN || eff_throttle > THR_MAX);
      tick_in.op_error        = req_tdata[12];
      tick_in.fault_active    = req_tdata[13];
      tick_in.fault_clearable = req_tdata[14];
      tick_in.ack_ok          = req_tdata[15];
   end

   assign tick_valid_in = req_accept || (tick_valid_ff && !tick_fire);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         tick_ff <= tick_in;
      end
   end

   tcs_frame_logic u_frame_logic (
      .tick       (tick_ff),
      .mode       (mode_ff),
      .torque_mem (torque_ff),
      .decision   (decision)
   );

   // Advance the state on each processed tick
   assign mode_in   = tick_fire ? decision.mode_next   : mode_ff;
   assign torque_in = tick_fire ? decision.torque_next : torque_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_DISABLE;
         torque_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         torque_ff <= torque_in;
      end
   end

   // Result register
   assign rsp_valid_in = out_free ? (tick_fire && decision.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire && decision.emit) begin
         frame_id_ff   <= decision.frame_id;
         payload_ff    <= decision.payload;
         mode_out_ff   <= decision.mode_next;
         torque_out_ff <= decision.torque_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, torque_out_ff, mode_out_ff, payload_ff, frame_id_ff};

endmodule

// ===== rtl/tcs_frame_logic.sv =====
`timescale 1ns / 1ps

module tcs_frame_logic import tcs_pkg::*; (
   input  tick_type            tick,
   input  mode_type            mode,
   input  logic [TORQUE_W-1:0] torque_mem,
   output decision_type        decision
);

   logic [QUARTER_W-1:0] quarter;
   logic [PROD2_W-1:0]   scaled;
   logic [QUOT_W-1:0]    quotient;
   logic [TORQUE_W-1:0]  torque;

   // Divide the throttle product by 100, saturate to 16 bits
   assign quarter  = tick.product[PRODUCT_W-1:2];
   assign scaled   = PROD2_W'(quarter) * PROD2_W'(RECIP_25);
   assign quotient = scaled[PROD2_W-1:RECIP_SH];
   assign torque   = (|quotient[QUOT_W-1:TORQUE_W]) ? {TORQUE_W{1'b1}}
                                                    : quotient[TORQUE_W-1:0];

   // Next state and frame choice
   always_comb begin
      decision.emit        = 1'b0;
      decision.frame_id    = ID_COMMAND;
      decision.payload     = PAYLOAD_FREE_ROLL;
      decision.mode_next   = mode;
      decision.torque_next = torque_mem;
      unique case (mode)
         MODE_ENABLE: begin
            decision.emit = 1'b1;
            if (tick.op_error || tick.fault_active) begin
               decision.torque_next = '0;
               decision.mode_next   = MODE_DISABLE;
            end else if (!tick.in_range) begin
               decision.torque_next = '0;
            end else begin
               decision.torque_next = torque;
               decision.payload     = PAYLOAD_TORQUE_FLAGS
                                    | PAYLOAD_W'(torque);
            end
         end
         MODE_WAIT: begin
            decision.emit      = 1'b1;
            decision.mode_next = tick.ack_ok ? MODE_ENABLE : MODE_DISABLE;
         end
         default: begin
            decision.mode_next = MODE_DISABLE;
            if (!tick.op_error) begin
               if (tick.fault_clearable) begin
                  decision.emit      = 1'b1;
                  decision.frame_id  = ID_PARAM_WRITE;
                  decision.payload   = PAYLOAD_FAULT_CLEAR;
                  decision.mode_next = MODE_WAIT;
               end else if (!tick.fault_active) begin
                  decision.emit        = 1'b1;
                  decision.mode_next   = MODE_ENABLE;
                  decision.torque_next = '0;
               end
            end
         end
      endcase
   end

endmodule

// ===== rtl/tcs_checker.sv =====
`timescale 1ns / 1ps

module tcs_checker import tcs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   logic [FRAME_ID_W-1:0] frame_id;
   logic [PAYLOAD_W-1:0]  payload;
   logic [MODE_W-1:0]     control_mode;
   logic [TORQUE_W-1:0]   last_torque;

   assign frame_id     = rsp_tdata[7:0];
   assign payload      = rsp_tdata[71:8];
   assign control_mode = rsp_tdata[73:72];
   assign last_torque  = rsp_tdata[89:74];

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Fault-clear frame always leads to the wait state with its fixed payload
   a_param_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_id == ID_PARAM_WRITE |->
         control_mode == MODE_WAIT && payload == PAYLOAD_FAULT_CLEAR)
      else $error("bad fault-clear frame");

   // A torque frame reports its torque as the last command
   a_torque_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_id == ID_COMMAND && payload[40] |->
         control_mode == MODE_ENABLE && last_torque == payload[15:0])
      else $error("torque frame and last torque disagree");

   // Free-roll frames carry no torque; torque memory is zero outside a torque run
   a_free_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_id == ID_COMMAND && !payload[40] |->
         payload == PAYLOAD_FREE_ROLL && last_torque == 16'd0)
      else $error("malformed free-roll frame");

   // Only the two identifiers appear, never the unused state code
   a_frame_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (frame_id == ID_COMMAND || frame_id == ID_PARAM_WRITE)
         && control_mode != 2'd3)
      else $error("unknown frame or state code");

endmodule

bind torque_command_sequencer_core tcs_checker u_tcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/torque_command_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module torque_command_sequencer_core_tb;
   import tcs_pkg::*;

   localparam logic [2:0] FULL_SCALE_ADDR = 3'd0;
   localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;
   localparam int FULL_SCALE_TOP  = 4681;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_ITEMS    = 220;

   // Throttle values on either side of each window edge
   localparam int unsigned THROTTLE_EDGES [10] = '{
      0, THR_MIN - 1, THR_MIN, THR_DEADBAND_LO, THR_DEADBAND_LO + 1,
      THR_DEADBAND_HI - 1, THR_DEADBAND_HI, THR_MAX, THR_MAX + 1, 4095
   };

   typedef struct packed {
      logic [THROTTLE_W-1:0] throttle;
      logic                  op_error;
      logic                  fault_active;
      logic                  fault_clearable;
      logic                  ack_ok;
   } control_tick_type;

   typedef struct {
      logic [FRAME_ID_W-1:0] frame_id;
      logic [PAYLOAD_W-1:0]  payload;
      logic [MODE_W-1:0]     control_mode;
      logic [TORQUE_W-1:0]   last_torque;
   } inverter_frame_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Mirror of the sequencer state
   mode_type             mode_q;
   logic [TORQUE_W-1:0]  torque_q;
   logic [MAXTQ_W-1:0]   full_scale_q;

   inverter_frame_type expected_frames [$];
   int                 error_count = 0;
   int                 idle_cycles;
   int                 sink_stall;
   bit                 sink_hold_tgl;
   bit                 sink_hold_seen;
   bit                 req_gaps_on;
   bit                 rsp_stalls_on;

   torque_command_sequencer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic control_tick_type make_tick(input int unsigned thr, input bit oe,
                                                  input bit fa, input bit fc, input bit ws);
      control_tick_type t;
      t.throttle        = thr[THROTTLE_W-1:0];
      t.op_error        = oe;
      t.fault_active    = fa;
      t.fault_clearable = fc;
      t.ack_ok          = ws;
      return t;
   endfunction

   // Mostly clean ticks with throttle in the window, some faults and noise
   function automatic control_tick_type rand_tick();
      int unsigned sel = $urandom_range(99);
      int unsigned thr;
      if (sel < 50)      thr = $urandom_range(THR_MAX, THR_MIN);
      else if (sel < 65) thr = $urandom_range(THR_DEADBAND_HI, THR_DEADBAND_LO);
      else if (sel < 80) thr = THROTTLE_EDGES[$urandom_range(9)];
      else               thr = $urandom_range(4095);
      return make_tick(thr, $urandom_range(99) < 10, $urandom_range(99) < 10,
                       $urandom_range(99) < 8, 1'($urandom_range(1)));
   endfunction

   // Advance the mirrored state by one tick and build the frame it sends
   function automatic void predict_frame(input control_tick_type t, output bit sends,
                                         output inverter_frame_type f);
      longint unsigned thr;
      longint unsigned tq;
      sends     = 1'b1;
      f.frame_id = ID_COMMAND;
      f.payload  = PAYLOAD_FREE_ROLL;
      case (mode_q)
         MODE_ENABLE: begin
            if (t.op_error || t.fault_active) begin
               torque_q = '0;
               mode_q   = MODE_DISABLE;
            end else begin
               thr = t.throttle;
               // clamp the dead zone down to its lower edge
               if (thr > THR_DEADBAND_LO && thr < THR_DEADBAND_HI) thr = THR_DEADBAND_LO;
               if (thr < THR_MIN || thr > THR_MAX) begin
                  torque_q = '0;
               end else begin
                  tq = (thr * full_scale_q * 10) / 1000;
                  if (tq > 64'hFFFF) tq = 64'hFFFF;
                  torque_q  = tq[TORQUE_W-1:0];
                  f.payload = PAYLOAD_TORQUE_FLAGS | {48'd0, torque_q};
               end
            end
         end
         MODE_WAIT: begin
            mode_q = t.ack_ok ? MODE_ENABLE : MODE_DISABLE;
         end
         default: begin
            mode_q = MODE_DISABLE;
            if (t.op_error) begin
               sends = 1'b0;
            end else if (t.fault_clearable) begin
               mode_q     = MODE_WAIT;
               f.frame_id = ID_PARAM_WRITE;
               f.payload  = PAYLOAD_FAULT_CLEAR;
            end else if (!t.fault_active) begin
               mode_q   = MODE_ENABLE;
               torque_q = '0;
            end else begin
               sends = 1'b0;
            end
         end
      endcase
      f.control_mode = mode_q;
      f.last_torque  = torque_q;
   endfunction

   // Offer one tick, wait for the transaction, queue any frame it sends
   task automatic send_tick(input control_tick_type t);
      int unsigned        gap;
      bit                 sends;
      inverter_frame_type f;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t.ack_ok, t.fault_clearable, t.fault_active, t.op_error,
                     t.throttle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame(t, sends, f);
      if (sends) expected_frames.push_back(f);
   endtask

   // Drop valid and let every tick in flight finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_frames.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == FULL_SCALE_ADDR) full_scale_q = data[MAXTQ_W-1:0];
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t ERROR %s expected %h actual %h", $time, field, want, got);
      error_count++;
   endtask

   // Disable and wait states: error lockout, fault clear, acknowledgement
   task automatic test_disable_paths();
      send_tick(make_tick(500, 1, 0, 1, 1));
      send_tick(make_tick(500, 0, 1, 0, 1));
      send_tick(make_tick(500, 0, 0, 1, 1));
      send_tick(make_tick(500, 1, 1, 0, 0));
      send_tick(make_tick(500, 0, 1, 1, 0));
      send_tick(make_tick(500, 0, 0, 0, 1));
      send_tick(make_tick(500, 1, 0, 0, 0));
      send_tick(make_tick(4095, 0, 0, 0, 0));
      send_tick(make_tick(500, 0, 1, 0, 0));
   endtask

   // Enable state: every edge of the throttle window and the dead zone
   task automatic test_throttle_window();
      send_tick(make_tick(0, 0, 0, 0, 0));
      foreach (THROTTLE_EDGES[i]) send_tick(make_tick(THROTTLE_EDGES[i], 0, 0, 0, 0));
      send_tick(make_tick(500, 0, 0, 0, 1));
   endtask

   // Full-scale and zero torque settings
   task automatic test_torque_scale();
      settle_block();
      csr_write(FULL_SCALE_ADDR, FULL_SCALE_TOP);
      send_tick(make_tick(500, 1, 0, 0, 0));
      send_tick(make_tick(500, 0, 0, 0, 0));
      send_tick(make_tick(THR_MAX, 0, 0, 0, 0));
      send_tick(make_tick(THR_DEADBAND_LO, 0, 0, 0, 0));
      send_tick(make_tick(THR_MIN, 0, 0, 0, 0));
      send_tick(make_tick(700, 0, 0, 0, 0));
      settle_block();
      csr_write(FULL_SCALE_ADDR, 0);
      send_tick(make_tick(THR_MAX, 0, 0, 0, 0));
   endtask

   // A write outside the register map leaves the full-scale torque alone
   task automatic test_unmapped_write();
      settle_block();
      csr_write(FULL_SCALE_ADDR, $urandom_range(FULL_SCALE_TOP));
      csr_write(UNMAPPED_ADDR, $urandom);
      repeat (6) send_tick(rand_tick());
   endtask

   task automatic test_random_traffic(input int unsigned full_scale, input bit gaps,
                                      input bit stalls);
      settle_block();
      csr_write(FULL_SCALE_ADDR, full_scale);
      req_gaps_on   = gaps;
      rsp_stalls_on = stalls;
      repeat (RANDOM_ITEMS) send_tick(rand_tick());
   endtask

   // Hold the result side off for a long stretch while ticks keep coming
   task automatic test_backpressure();
      settle_block();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      sink_hold_tgl = ~sink_hold_tgl;
      repeat (40) send_tick(rand_tick());
   endtask

   // Result side: random stalls, or a long hold when asked
   always @(posedge clock) begin : sink
      int unsigned gap;
      if (reset) begin
         rsp_tready     <= 1'b0;
         sink_stall     <= 0;
         sink_hold_seen <= sink_hold_tgl;
      end else if (sink_hold_tgl != sink_hold_seen) begin
         rsp_tready     <= 1'b0;
         sink_stall     <= HOLD_CYCLES;
         sink_hold_seen <= sink_hold_tgl;
      end else if (sink_stall > 0) begin
         rsp_tready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (rsp_stalls_on) begin
         gap = pick_gap();
         rsp_tready <= (gap == 0);
         sink_stall <= (gap == 0) ? 0 : gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each frame transaction with the oldest expectation
   always @(posedge clock) begin : frame_check
      inverter_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t ERROR unexpected frame, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tdata[7:0] !== want.frame_id)
               report_mismatch("frame_id", 64'(want.frame_id), 64'(rsp_tdata[7:0]));
            if (rsp_tdata[71:8] !== want.payload)
               report_mismatch("payload", want.payload, rsp_tdata[71:8]);
            if (rsp_tdata[73:72] !== want.control_mode)
               report_mismatch("control_mode", 64'(want.control_mode),
                               64'(rsp_tdata[73:72]));
            if (rsp_tdata[89:74] !== want.last_torque)
               report_mismatch("last_torque", 64'(want.last_torque),
                               64'(rsp_tdata[89:74]));
            if (rsp_tdata[95:90] !== 6'd0)
               report_mismatch("zero fill", 64'd0, 64'(rsp_tdata[95:90]));
         end
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ERROR timeout with %0d frames outstanding", $time,
                  expected_frames.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      sink_hold_tgl = 1'b0;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      mode_q        = MODE_DISABLE;
      torque_q      = '0;
      full_scale_q  = FULL_SCALE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_disable_paths();
      test_throttle_window();
      test_torque_scale();
      test_unmapped_write();
      test_random_traffic($urandom_range(FULL_SCALE_TOP), 1'b1, 1'b1);
      test_random_traffic(FULL_SCALE_TOP, 1'b0, 1'b0);
      test_random_traffic(0, 1'b1, 1'b0);
      test_random_traffic($urandom_range(FULL_SCALE_TOP), 1'b0, 1'b1);
      test_random_traffic(1, 1'b1, 1'b1);
      test_backpressure();

      // Drain and give stray frames a chance to show up
      req_tvalid <= 1'b0;
      while (expected_frames.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
